/* src/pffl_pkg.sv */
// ----------------------------------------------------------------------------
// pffl_pkg
// Shared types, widths and helpers for the page frame free list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pffl_pkg;

	localparam int FRAME_W     = 16;
	localparam int NUM_FRAMES  = 1 << FRAME_W;
	localparam int COUNT_W     = FRAME_W + 1;
	localparam int END_W       = FRAME_W + 2;
	localparam int CFG_W       = COUNT_W;
	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2
	} action_t;

	typedef enum logic [0:0] {
		REG_SKIP_BASE   = 1'b0,
		REG_SKIP_FRAMES = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ST_OK  = 1'b0,
		ST_OOM = 1'b1
	} status_t;

	typedef struct packed {
		frame_t skip_lo;
		count_t skip_frames;
	} cfg_t;

	typedef struct packed {
		action_t action;
		frame_t  region_base_frame;
		count_t  region_pages;
		logic    region_usable;
		frame_t  freed_frame;
	} req_t;

	typedef struct packed {
		frame_t  alloc_frame;
		status_t status;
		count_t  free_count;
		count_t  total_count;
	} res_t;

	typedef struct packed {
		logic   we;
		frame_t addr;
		frame_t data;
	} ram_wr_t;

	function automatic count_t sat_inc(input count_t c);
		sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + count_t'(1);
	endfunction

endpackage

`default_nettype wire

/* src/page_frame_free_list_unit.sv */
// ----------------------------------------------------------------------------
// page_frame_free_list_unit
// LIFO free list of page frames kept as a next-link RAM, a head and counters.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | contents
//  ---------+-----------+-------------------------+------------------------------
//  s_axis   | in        | tvalid/tready           | request: action, region, freed frame
//  m_axis   | out       | tvalid/tready           | result: frame, status, counts
//  cfg      | in        | cfg_we (no wait)        | skip window base and length
//
//  Free, unknown action, unusable add and allocate on an empty list go straight
//  to the done step; allocate passes the pop step first (one registered read of
//  the link RAM). A usable add walks base up to the region end, capped at the
//  top frame, one frame per cycle; the single link RAM write port pushes each
//  frame outside the skip window. s_axis_tready is high only while the sequencer
//  is idle. Reset clears head and counts; the link RAM is not cleared (no
//  sweep). A result waiting on m_axis does not block the next request; the
//  sequencer holds in its final step only if the output register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_free_list_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [pffl_pkg::CFG_W-1:0]          cfg_wdata,
	// request stream
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// region_base_frame[15:0], region_pages[32:16], region_usable[33],
	// freed_frame[49:34], zero fill [55:50]
	input  wire logic [pffl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action[1:0]
	input  wire logic [pffl_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	// result stream
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// alloc_frame[15:0], free_count[32:16], total_count[49:33], zero fill [55:50]
	output logic [pffl_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// status[0]
	output logic [pffl_pkg::OUT_TUSER_W-1:0]         m_axis_tuser
);

	pffl_pkg::cfg_t    cfg_q;
	pffl_pkg::req_t    req;
	pffl_pkg::res_t    res;
	pffl_pkg::res_t    out_q;
	pffl_pkg::ram_wr_t ram_wr;
	pffl_pkg::frame_t  ram_raddr;
	pffl_pkg::frame_t  ram_rdata;
	logic              out_valid_q;
	logic              res_valid;
	logic              slot_free;

	// Configuration: take the write on the edge, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (pffl_pkg::cfg_reg_t'(cfg_index))
				pffl_pkg::REG_SKIP_BASE: begin
					cfg_q.skip_lo <= cfg_wdata[pffl_pkg::FRAME_W-1:0];
				end
				pffl_pkg::REG_SKIP_FRAMES: begin
					cfg_q.skip_frames <= cfg_wdata;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Unpack the request fields.
	assign req.action            = pffl_pkg::action_t'(s_axis_tuser);
	assign req.region_base_frame = s_axis_tdata[15:0];
	assign req.region_pages      = s_axis_tdata[32:16];
	assign req.region_usable     = s_axis_tdata[33];
	assign req.freed_frame       = s_axis_tdata[49:34];

	// Output register: free when empty or being drained this cycle.
	assign slot_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.total_count, out_q.free_count, out_q.alloc_frame};
	assign m_axis_tuser  = out_q.status;

	// Sequencer and walk datapath.
	pffl_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.req_valid     (s_axis_tvalid),
		.req           (req),
		.req_ready     (s_axis_tready),
		.res_slot_free (slot_free),
		.res_valid     (res_valid),
		.res           (res),
		.ram_wr        (ram_wr),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	// Next-link store, one entry per frame.
	pffl_ram #(
		.WIDTH (pffl_pkg::FRAME_W),
		.DEPTH (pffl_pkg::NUM_FRAMES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* src/pffl_ram.sv */
// ----------------------------------------------------------------------------
// pffl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/pffl_core.sv */
// ----------------------------------------------------------------------------
// pffl_core
// Sequencer and shared frame-walk datapath: push, pop and region walk.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pffl_pkg::cfg_t   cfg,
	input  wire logic             req_valid,
	input  wire pffl_pkg::req_t   req,
	output logic                  req_ready,
	input  wire logic             res_slot_free,
	output logic                  res_valid,
	output pffl_pkg::res_t        res,
	output pffl_pkg::ram_wr_t     ram_wr,
	output pffl_pkg::frame_t      ram_raddr,
	input  wire pffl_pkg::frame_t ram_rdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_POP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	pffl_pkg::frame_t head_q;
	pffl_pkg::count_t free_q;
	pffl_pkg::count_t total_q;
	pffl_pkg::count_t frame_q;
	logic [pffl_pkg::END_W-1:0] end_q;
	logic [pffl_pkg::END_W-1:0] win_hi_q;
	pffl_pkg::frame_t  res_frame_q;
	pffl_pkg::status_t res_status_q;

	logic accept;
	logic walk_more;
	logic in_window;
	logic walk_push;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);

	// shared walk compare: frame still inside region and frame space, and skip test
	assign walk_more = ({1'b0, frame_q} < end_q) && !frame_q[pffl_pkg::FRAME_W];
	assign in_window = (frame_q >= {1'b0, cfg.skip_lo}) && ({1'b0, frame_q} < win_hi_q);
	assign walk_push = (state_q == S_WALK) && walk_more && !in_window;

	assign ram_raddr = head_q;

	always_comb begin
		ram_wr.we   = 1'b0;
		ram_wr.addr = req.freed_frame;
		ram_wr.data = head_q;
		if (walk_push) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = frame_q[pffl_pkg::FRAME_W-1:0];
		end else if (accept && req.action == pffl_pkg::ACT_FREE) begin
			ram_wr.we = 1'b1;
		end
	end

	assign res_valid       = (state_q == S_DONE) && res_slot_free;
	assign res.alloc_frame = res_frame_q;
	assign res.status      = res_status_q;
	assign res.free_count  = free_q;
	assign res.total_count = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			free_q  <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.action)
							pffl_pkg::ACT_ADD: begin
								state_q <= req.region_usable ? S_WALK : S_DONE;
							end
							pffl_pkg::ACT_ALLOC: begin
								state_q <= (free_q == '0) ? S_DONE : S_POP;
							end
							pffl_pkg::ACT_FREE: begin
								head_q  <= req.freed_frame;
								free_q  <= pffl_pkg::sat_inc(free_q);
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (!walk_more) begin
						state_q <= S_DONE;
					end else if (walk_push) begin
						head_q  <= frame_q[pffl_pkg::FRAME_W-1:0];
						free_q  <= pffl_pkg::sat_inc(free_q);
						total_q <= pffl_pkg::sat_inc(total_q);
					end
				end
				S_POP: begin
					head_q  <= ram_rdata;
					free_q  <= free_q - pffl_pkg::count_t'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q      <= {1'b0, req.region_base_frame};
			end_q        <= pffl_pkg::END_W'(req.region_base_frame)
			                + pffl_pkg::END_W'(req.region_pages);
			win_hi_q     <= pffl_pkg::END_W'(cfg.skip_lo)
			                + pffl_pkg::END_W'(cfg.skip_frames);
			res_frame_q  <= '0;
			res_status_q <= pffl_pkg::ST_OK;
			if (req.action == pffl_pkg::ACT_ALLOC) begin
				if (free_q == '0) begin
					res_status_q <= pffl_pkg::ST_OOM;
				end else begin
					res_frame_q <= head_q;
				end
			end
		end else if (state_q == S_WALK) begin
			frame_q <= frame_q + pffl_pkg::count_t'(1);
		end
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives page_frame_free_list_unit with directed corner requests and then
// random request mixes. The skip window changes between phases, and the
// handshake idling pattern changes between some of them. Every result is
// checked against a behavioral free list that runs alongside the stimulus.
// ----------------------------------------------------------------------------
module testbench;

	// Action code that the block has no use for; it must leave state alone.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int TOP_FRAME = pffl_pkg::NUM_FRAMES - 1;
	// A full 65536-frame region walk is the longest quiet stretch; allow
	// several times that before calling the run hung.
	localparam int STALL_LIMIT = 300000;

	typedef struct {
		logic [1:0]       act;
		pffl_pkg::frame_t base;
		pffl_pkg::count_t pages;
		logic             usable;
		pffl_pkg::frame_t freed;
	} request_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [0:0]                       cfg_index = pffl_pkg::REG_SKIP_BASE;
	logic [pffl_pkg::CFG_W-1:0]       cfg_wdata = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	// region_base_frame[15:0], region_pages[32:16], region_usable[33],
	// freed_frame[49:34], zero fill [55:50]
	logic [pffl_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// action[1:0]
	logic [pffl_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	// alloc_frame[15:0], free_count[32:16], total_count[49:33], zero fill [55:50]
	logic [pffl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	// status[0]
	logic [pffl_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

	page_frame_free_list_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow free list: link store, head, counters and the skip window.
	pffl_pkg::frame_t link_mem [pffl_pkg::NUM_FRAMES];
	bit               link_written [pffl_pkg::NUM_FRAMES];
	pffl_pkg::frame_t head = '0;
	pffl_pkg::count_t listed = '0;
	pffl_pkg::count_t added = '0;
	pffl_pkg::frame_t win_base = '0;
	pffl_pkg::count_t win_len = '0;

	pffl_pkg::frame_t loaned_frames[$];   // frames handed out and not yet given back
	request_t         requests[$];        // requests waiting for the driver
	pffl_pkg::res_t   count_reports[$];   // outcome of each issued request, in order
	request_t         cur_req;
	pffl_pkg::res_t   want;

	int send_gap_pct = 0;
	int take_gap_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	function automatic void push_frame(pffl_pkg::frame_t f);
		link_mem[f] = head;
		link_written[f] = 1'b1;
		head = f;
		if (listed != pffl_pkg::COUNT_MAX)
			listed = listed + 1'b1;
	endfunction

	// Apply one request to the shadow list and return the result it yields.
	function automatic pffl_pkg::res_t list_update(request_t r);
		pffl_pkg::res_t o;
		int             stop;
		int             win_end;
		int             f;
		o = '0;
		case (r.act)
			pffl_pkg::ACT_ADD: begin
				if (r.usable) begin
					// no wrap: the walk ends at the top frame, the window may run past it
					stop = int'(r.base) + int'(r.pages);
					win_end = int'(win_base) + int'(win_len);
					for (f = int'(r.base); f < stop && f <= TOP_FRAME; f++) begin
						if (f >= int'(win_base) && f < win_end)
							continue;
						push_frame(pffl_pkg::frame_t'(f));
						if (added != pffl_pkg::COUNT_MAX)
							added = added + 1'b1;
					end
				end
			end
			pffl_pkg::ACT_ALLOC: begin
				if (listed == 0) begin
					o.status = pffl_pkg::ST_OOM;
				end else begin
					o.alloc_frame = head;
					loaned_frames.push_back(head);
					head = link_mem[head];
					listed = listed - 1'b1;
				end
			end
			pffl_pkg::ACT_FREE: begin
				push_frame(r.freed);
			end
			default: ;
		endcase
		o.free_count = listed;
		o.total_count = added;
		return o;
	endfunction

	task automatic issue(request_t r);
		requests.push_back(r);
		count_reports.push_back(list_update(r));
	endtask

	task automatic send(logic [1:0] act, pffl_pkg::frame_t base, pffl_pkg::count_t pages,
			logic usable, pffl_pkg::frame_t freed);
		request_t r;
		r.act = act;
		r.base = base;
		r.pages = pages;
		r.usable = usable;
		r.freed = freed;
		issue(r);
	endtask

	// Mostly small regions; a few near the top frame carry huge page counts
	// that stay cheap because the walk stops at the top.
	task automatic random_requests(int n);
		request_t r;
		int       pick;
		int       drain;
		int       idx;
		int       i;
		drain = 0;
		for (i = 0; i < n; i++) begin
			r.base = pffl_pkg::frame_t'($urandom);
			r.pages = pffl_pkg::count_t'($urandom_range(0, 12));
			r.usable = 1'b1;
			r.freed = pffl_pkg::frame_t'($urandom);
			pick = $urandom_range(99);
			if (drain == 0 && pick < 4)
				drain = $urandom_range(5, 30);
			if (drain > 0) begin
				// run of allocates to empty the list and reach out of memory
				r.act = pffl_pkg::ACT_ALLOC;
				drain--;
			end else if (pick < 10) begin
				r.act = ACT_UNUSED;
			end else if (pick < 34) begin
				r.act = pffl_pkg::ACT_ADD;
				r.usable = ($urandom_range(9) != 0);
				case ($urandom_range(7))
					0: begin
						r.base = pffl_pkg::frame_t'(TOP_FRAME - int'($urandom_range(0, 150)));
						r.pages = pffl_pkg::count_t'($urandom);
					end
					1: begin
						// straddle the start of the skip window
						r.base = pffl_pkg::frame_t'(win_base - $urandom_range(0, 8));
						r.pages = pffl_pkg::count_t'($urandom_range(0, 24));
					end
					default: ;
				endcase
			end else if (pick < 64) begin
				r.act = pffl_pkg::ACT_ALLOC;
			end else begin
				r.act = pffl_pkg::ACT_FREE;
				if (loaned_frames.size() != 0 && $urandom_range(9) < 7) begin
					idx = $urandom_range(loaned_frames.size() - 1);
					r.freed = loaned_frames[idx];
					loaned_frames.delete(idx);
				end
			end
			// an allocate must never follow a link that was never stored
			if (r.act == pffl_pkg::ACT_ALLOC && listed != 0 && !link_written[head])
				r.act = ACT_UNUSED;
			issue(r);
		end
	endtask

	task automatic write_skip(pffl_pkg::cfg_reg_t idx, pffl_pkg::count_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pffl_pkg::REG_SKIP_BASE)
			win_base = val[pffl_pkg::FRAME_W-1:0];
		else
			win_len = val;
	endtask

	// Hold until every request has been taken and every result has come back.
	task automatic settle();
		while (requests.size() != 0 || count_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Driver: advance to the next request once the current one transfers,
	// or leave the request stream idle at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				cur_req = requests.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {6'b0, cur_req.freed, cur_req.usable, cur_req.pages,
					cur_req.base};
				s_axis_tuser <= cur_req.act;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transfer with the oldest outcome, and
	// stall the result stream at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (count_reports.size() == 0) begin
					$error("result with nothing outstanding: alloc_frame %0d",
						m_axis_tdata[15:0]);
					mismatches++;
				end else begin
					want = count_reports.pop_front();
					if (m_axis_tdata[15:0] !== want.alloc_frame) begin
						$error("alloc_frame: expected %0d, got %0d", want.alloc_frame,
							m_axis_tdata[15:0]);
						mismatches++;
					end
					if (m_axis_tuser[0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status,
							m_axis_tuser[0]);
						mismatches++;
					end
					if (m_axis_tdata[32:16] !== want.free_count) begin
						$error("free_count: expected %0d, got %0d", want.free_count,
							m_axis_tdata[32:16]);
						mismatches++;
					end
					if (m_axis_tdata[49:33] !== want.total_count) begin
						$error("total_count: expected %0d, got %0d", want.total_count,
							m_axis_tdata[49:33]);
						mismatches++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	// Watchdog: end the run if neither stream transfers for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly, receiver heavily; skip window at reset (empty).
		send_gap_pct = 23;
		take_gap_pct = 65;
		send(pffl_pkg::ACT_ALLOC, '0, '0, 1'b0, '0);                 // empty list
		send(ACT_UNUSED, 16'hFFFF, 17'h1FFFF, 1'b1, 16'hFFFF);
		send(pffl_pkg::ACT_FREE, '0, '0, 1'b0, 16'd0);               // frame 0 is ordinary
		send(pffl_pkg::ACT_FREE, '0, '0, 1'b0, 16'hFFFF);
		send(pffl_pkg::ACT_ADD, 16'd100, 17'd50, 1'b0, '0);          // not usable
		send(pffl_pkg::ACT_ADD, 16'd10, 17'd0, 1'b1, '0);            // no pages
		send(pffl_pkg::ACT_ADD, 16'd65530, 17'h1FFFF, 1'b1, '0);     // runs past the top
		repeat (3) send(pffl_pkg::ACT_ALLOC, '0, '0, 1'b0, '0);
		send(pffl_pkg::ACT_FREE, '0, '0, 1'b0, 16'd65531);           // already on the list
		// drain the list completely, then one more for out of memory
		repeat (7) send(pffl_pkg::ACT_ALLOC, '0, '0, 1'b0, '0);
		settle();

		// Window from frame 65500 reaching past the top frame.
		write_skip(pffl_pkg::REG_SKIP_BASE, pffl_pkg::count_t'(16'd65500));
		write_skip(pffl_pkg::REG_SKIP_FRAMES, pffl_pkg::count_t'(65536));
		send(pffl_pkg::ACT_ADD, 16'd65490, 17'd100, 1'b1, '0);
		send(pffl_pkg::ACT_ADD, 16'd65400, 17'h1FFFF, 1'b1, '0);
		send(pffl_pkg::ACT_ALLOC, '0, '0, 1'b0, '0);
		send(pffl_pkg::ACT_FREE, '0, '0, 1'b0, 16'd0);
		random_requests(80);
		settle();

		// Sender idles heavily, receiver lightly; random window.
		send_gap_pct = 65;
		take_gap_pct = 23;
		write_skip(pffl_pkg::REG_SKIP_BASE, pffl_pkg::count_t'($urandom_range(0, 65535)));
		write_skip(pffl_pkg::REG_SKIP_FRAMES, pffl_pkg::count_t'($urandom_range(0, 3000)));
		random_requests(140);
		settle();

		// Window covering every frame: adds push nothing.
		write_skip(pffl_pkg::REG_SKIP_BASE, pffl_pkg::count_t'(0));
		write_skip(pffl_pkg::REG_SKIP_FRAMES, pffl_pkg::count_t'(65536));
		random_requests(60);
		settle();

		// No idling from here on; single-frame window at the top.
		send_gap_pct = 0;
		take_gap_pct = 0;
		write_skip(pffl_pkg::REG_SKIP_BASE, pffl_pkg::count_t'(16'hFFFF));
		write_skip(pffl_pkg::REG_SKIP_FRAMES, pffl_pkg::count_t'(1));
		random_requests(120);
		settle();

		// Empty window; two whole-memory adds drive both counters into saturation.
		write_skip(pffl_pkg::REG_SKIP_BASE, pffl_pkg::count_t'(0));
		write_skip(pffl_pkg::REG_SKIP_FRAMES, pffl_pkg::count_t'(0));
		repeat (2) send(pffl_pkg::ACT_ADD, 16'd0, pffl_pkg::count_t'(65536), 1'b1, '0);
		random_requests(130);
		settle();

		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
